// ===== design/srcd_pkg.sv =====
package srcd_pkg;

  // Width of the pen coordinates kept inside the decoder.
  localparam int COORD_BITS = 16;
  localparam int OUT_BITS   = 16;

  localparam logic [7:0] END_BYTE  = 8'hFF;
  localparam logic [7:0] DATA_MAX  = 8'h7F;
  localparam logic [7:0] CMD_E0    = 8'hE0;
  localparam logic [7:0] HI_MASK   = 8'hF0;
  localparam logic [3:0] LO_MAX    = 4'h7;
  localparam logic [7:0] SKIP_BIAS = 8'h08;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef enum logic [1:0] {
    REG_X_BASE,
    REG_Y_BASE,
    REG_PLANE_INDEX
  } cfg_reg_t;

  typedef struct packed {
    logic [11:0] x_base;
    logic [11:0] y_base;
    logic [1:0]  plane_index;
  } cfg_t;

  typedef struct packed {
    coord_t      pen_x;
    coord_t      pen_y;
    logic [3:0]  row_run;
    logic [3:0]  skip_run;
    logic [4:0]  long_run;
    logic        skip_pending;
    logic        long_pending;
    logic        long_skip_mode;
    logic [7:0]  extra_skip;
    logic        await_second;
  } state_t;

  typedef struct packed {
    logic                       pixel_write;
    logic signed [OUT_BITS-1:0] pixel_x;
    logic signed [OUT_BITS-1:0] pixel_y;
    logic [7:0]                 colour_index;
    logic                       transparent;
    logic                       plane_done;
  } result_t;

  function automatic coord_t line_start_x(input cfg_t cfg);
    logic [31:0] s;
    s = 32'(cfg.x_base) + 32'(cfg.plane_index);
    return COORD_BITS'(s);
  endfunction

  function automatic state_t plane_start(input cfg_t cfg);
    state_t s;
    s = '0;
    s.pen_x = line_start_x(cfg);
    s.pen_y = COORD_BITS'(cfg.y_base);
    return s;
  endfunction

  // Four columns per skip step, since the planes are interleaved.
  function automatic coord_t extra_offset(input logic [7:0] e);
    logic signed [31:0] s;
    s = 32'($signed(e));
    return COORD_BITS'(s <<< 2);
  endfunction

  function automatic logic signed [OUT_BITS-1:0] coord_out(input coord_t v);
    logic signed [31:0] s;
    s = 32'($signed(v));
    return s[OUT_BITS-1:0];
  endfunction

endpackage

// ===== design/sprite_run_code_decoder.sv =====
// Run-coded sprite plane decoder.
// Input channel (in_valid, in_stall, code_byte) takes one code byte per item.
// Output channel (out_valid, out_stall, pixel_* fields) gives exactly one
// result item per code byte: a pixel write, or an item with pixel_write low
// and zeroed coordinates for a command byte. plane_done marks the 0xFF byte,
// after which the decoder restarts the plane from its origin.
// out_valid rises once the decoded item is in the result register: an
// accepted byte lands in the input register, and from there the decoded item
// is loaded into the result register. Throughput is one item per cycle while
// the receiver does not stall, as the pen and run counters update per byte.
// When the receiver stalls, the result register holds and one more item can
// wait in the input register; in_stall rises only when both are full.
// Configuration is written through cfg_write, cfg_index and cfg_data while the
// block is idle; any write to a known register also restarts the plane.
// Synchronous reset clears the origin registers to zero, empties both
// registers and puts the decoder in its plane start state.
module sprite_run_code_decoder
  import srcd_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [1:0]                 cfg_index,
  input  logic [11:0]                cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 code_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       pixel_write,
  output logic signed [OUT_BITS-1:0] pixel_x,
  output logic signed [OUT_BITS-1:0] pixel_y,
  output logic [7:0]                 colour_index,
  output logic                       transparent,
  output logic                       plane_done
);

  cfg_t       cfg;
  cfg_t       cfg_next;
  logic       cfg_hit;
  state_t     st;
  state_t     st_step;
  result_t    res;
  result_t    res_q;
  logic       in_q_valid;
  logic [7:0] in_q_byte;
  logic       out_free;
  logic       step;

  assign out_free = !out_valid || !out_stall;
  assign step     = in_q_valid && out_free;
  assign in_stall = in_q_valid && !out_free;

  srcd_decode u_decode (
    .st        (st),
    .cfg       (cfg),
    .code_byte (in_q_byte),
    .st_next   (st_step),
    .res       (res)
  );

  always_comb begin
    cfg_next = cfg;
    cfg_hit  = 1'b0;
    if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_X_BASE: begin
          cfg_next.x_base = cfg_data;
          cfg_hit = 1'b1;
        end
        REG_Y_BASE: begin
          cfg_next.y_base = cfg_data;
          cfg_hit = 1'b1;
        end
        REG_PLANE_INDEX: begin
          cfg_next.plane_index = cfg_data[1:0];
          cfg_hit = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg        <= '0;
      st         <= plane_start('0);
      in_q_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      cfg <= cfg_next;
      if (cfg_hit) begin
        st <= plane_start(cfg_next);
      end else if (step) begin
        st <= st_step;
      end
      if (!in_stall) begin
        in_q_valid <= in_valid;
      end
      if (out_free) begin
        out_valid <= in_q_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_q_byte <= code_byte;
    end
    if (step) begin
      res_q <= res;
    end
  end

  assign pixel_write  = res_q.pixel_write;
  assign pixel_x      = res_q.pixel_x;
  assign pixel_y      = res_q.pixel_y;
  assign colour_index = res_q.colour_index;
  assign transparent  = res_q.transparent;
  assign plane_done   = res_q.plane_done;

`ifndef SYNTHESIS
  a_one_run: assert property (@(posedge clk) disable iff (rst)
    $countones({st.row_run != 4'd0, st.skip_run != 4'd0, st.long_run != 5'd0}) <= 1)
    else $error("more than one run counter active");

  a_await_no_run: assert property (@(posedge clk) disable iff (rst)
    st.await_second |-> (st.row_run == 4'd0 && st.skip_run == 4'd0 && st.long_run == 5'd0))
    else $error("second command byte awaited inside a run");

  a_done_restart: assert property (@(posedge clk) disable iff (rst)
    (step && res.plane_done) |=> (st == plane_start(cfg)))
    else $error("plane end did not restart the decoder");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pixel_write) |->
      (pixel_x == '0 && pixel_y == '0 && colour_index == 8'd0 && !transparent))
    else $error("command item carries pixel fields");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (in_q_valid && out_valid))
    else $error("input stalled while a register is free");
`endif

endmodule

// ===== design/srcd_decode.sv =====
module srcd_decode
  import srcd_pkg::*;
(
  input  state_t     st,
  input  cfg_t       cfg,
  input  logic [7:0] code_byte,
  output state_t     st_next,
  output result_t    res
);

  logic [3:0] lo;
  logic [3:0] hi;
  state_t     ns;
  result_t    r;

  assign lo = code_byte[3:0];
  assign hi = code_byte[7:4];

  always_comb begin
    ns = st;
    r  = '0;
    if (st.await_second) begin
      ns.await_second = 1'b0;
      ns.long_run     = {1'b0, hi};
      ns.long_pending = 1'b1;
      if (lo != 4'd0) begin
        ns.long_skip_mode = 1'b1;
        ns.extra_skip     = {4'd0, lo} - SKIP_BIAS;
      end
    end else if (st.row_run != 4'd0 || st.skip_run != 4'd0 || st.long_run != 5'd0) begin
      r.pixel_write  = 1'b1;
      r.pixel_x      = coord_out(st.pen_x);
      r.pixel_y      = coord_out(st.pen_y);
      r.colour_index = code_byte;
      r.transparent  = (code_byte == 8'd0);
      ns.pen_x = st.pen_x + COORD_BITS'(4);
      if (ns.row_run != 4'd0) begin
        ns.row_run = ns.row_run - 4'd1;
        if (ns.row_run == 4'd0) begin
          ns.pen_y = ns.pen_y + COORD_BITS'(1);
          ns.pen_x = line_start_x(cfg);
        end
      end
      if (ns.skip_run != 4'd0) begin
        ns.skip_run = ns.skip_run - 4'd1;
      end
      if (ns.skip_run == 4'd0 && ns.skip_pending) begin
        ns.pen_x        = ns.pen_x + extra_offset(ns.extra_skip);
        ns.extra_skip   = 8'd0;
        ns.skip_pending = 1'b0;
      end
      if (ns.long_run != 5'd0) begin
        ns.long_run = ns.long_run - 5'd1;
      end
      // A pending long run closes either with a skip or with a line end.
      if (ns.long_run == 5'd0 && ns.long_pending) begin
        if (ns.long_skip_mode) begin
          ns.pen_x      = ns.pen_x + extra_offset(ns.extra_skip);
          ns.extra_skip = 8'd0;
        end else begin
          ns.pen_y = ns.pen_y + COORD_BITS'(1);
          ns.pen_x = line_start_x(cfg);
        end
        ns.long_pending   = 1'b0;
        ns.long_skip_mode = 1'b0;
      end
    end else if (code_byte == 8'd0) begin
      ns.pen_y = st.pen_y + COORD_BITS'(1);
      ns.pen_x = line_start_x(cfg);
    end else if (code_byte > DATA_MAX) begin
      if (lo > LO_MAX && (code_byte & HI_MASK) == CMD_E0) begin
        ns.pen_x = st.pen_x + COORD_BITS'({lo, 2'b00}) - COORD_BITS'(8);
        ns.await_second = 1'b1;
      end else begin
        ns.long_run = {1'b0, lo};
        ns.pen_x    = st.pen_x + COORD_BITS'({hi, 2'b00}) - COORD_BITS'(32);
      end
    end else begin
      if (lo == 4'd0) begin
        ns.row_run = hi;
      end else if (lo <= LO_MAX) begin
        ns.skip_run = lo + hi;
      end else begin
        ns.skip_run     = hi;
        ns.extra_skip   = st.extra_skip + {4'd0, lo} - SKIP_BIAS;
        ns.skip_pending = 1'b1;
      end
    end
    if (code_byte == END_BYTE) begin
      r.plane_done = 1'b1;
      ns = plane_start(cfg);
    end
  end

  assign st_next = ns;
  assign res     = r;

endmodule

// ===== tb/sprite_run_code_decoder_tb.sv =====
`timescale 1ns / 100ps

module sprite_run_code_decoder_tb;
  import srcd_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES = 64;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASES = 8;
  localparam int PHASE_BYTES = 140;

  // Tracks the decoder's pen and run state and holds the pixel items still owed.
  class pixel_scoreboard;
    logic [11:0] x_base, y_base;
    logic [1:0]  plane;
    coord_t      pen_x, pen_y;
    logic [3:0]  row_run, skip_run;
    logic [4:0]  long_run;
    logic [7:0]  extra_skip;
    bit          skip_pending, long_pending, long_skip_mode, await_second;
    result_t     expected_pixels[$];
    int          errors, pixels, planes;

    function new();
      x_base = '0;
      y_base = '0;
      plane = '0;
      errors = 0;
      pixels = 0;
      planes = 0;
      restart_plane();
    endfunction

    function void restart_plane();
      pen_x = coord_t'(x_base) + coord_t'(plane);
      pen_y = coord_t'(y_base);
      row_run = '0;
      skip_run = '0;
      long_run = '0;
      extra_skip = '0;
      skip_pending = 0;
      long_pending = 0;
      long_skip_mode = 0;
      await_second = 0;
    endfunction

    function void next_row();
      pen_y = pen_y + coord_t'(1);
      pen_x = coord_t'(x_base) + coord_t'(plane);
    endfunction

    // The accumulated skip is signed and counts groups of four columns.
    function void apply_extra_skip();
      coord_t step;
      step = {{(COORD_BITS-8){extra_skip[7]}}, extra_skip};
      pen_x = pen_x + (step << 2);
      extra_skip = '0;
    endfunction

    function void apply_reg(logic [1:0] idx, logic [11:0] data);
      case (idx)
        REG_X_BASE: x_base = data;
        REG_Y_BASE: y_base = data;
        REG_PLANE_INDEX: plane = data[1:0];
        default: return;
      endcase
      restart_plane();
    endfunction

    function void note_byte(logic [7:0] b);
      result_t r;
      logic [3:0] lo, hi;
      r = '0;
      lo = b[3:0];
      hi = b[7:4];
      if (await_second) begin
        await_second = 0;
        long_run = {1'b0, hi};
        long_pending = 1;
        if (lo != 4'h0) begin
          long_skip_mode = 1;
          extra_skip = {4'h0, lo} - SKIP_BIAS;
        end
      end else if (row_run != 0 || skip_run != 0 || long_run != 0) begin
        r.pixel_write = 1'b1;
        r.pixel_x = OUT_BITS'($signed(pen_x));
        r.pixel_y = OUT_BITS'($signed(pen_y));
        r.colour_index = b;
        r.transparent = (b == 8'h00);
        pen_x = pen_x + coord_t'(4);
        if (row_run != 0) begin
          row_run--;
          if (row_run == 0) next_row();
        end
        if (skip_run != 0) skip_run--;
        if (skip_run == 0 && skip_pending) begin
          apply_extra_skip();
          skip_pending = 0;
        end
        if (long_run != 0) long_run--;
        if (long_run == 0 && long_pending) begin
          if (long_skip_mode) apply_extra_skip();
          else next_row();
          long_pending = 0;
          long_skip_mode = 0;
        end
      end else if (b == 8'h00) begin
        next_row();
      end else if (b > DATA_MAX) begin
        if (lo > LO_MAX && (b & HI_MASK) == CMD_E0) begin
          pen_x = pen_x + (coord_t'(lo) << 2) - coord_t'(SKIP_BIAS);
          await_second = 1;
        end else begin
          long_run = {1'b0, lo};
          pen_x = pen_x + (coord_t'(hi) << 2) - coord_t'(32);
        end
      end else if (lo == 4'h0) begin
        row_run = hi;
      end else if (lo <= LO_MAX) begin
        skip_run = lo + hi;
      end else begin
        skip_run = hi;
        extra_skip = extra_skip + {4'h0, lo} - SKIP_BIAS;
        skip_pending = 1;
      end
      if (b == END_BYTE) begin
        r.plane_done = 1'b1;
        restart_plane();
      end
      expected_pixels.insert(expected_pixels.size(), r);
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_pixels.size() == 0) begin
        $error("result item arrived with no code byte outstanding");
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      compare_field("pixel_write", want.pixel_write, got.pixel_write);
      compare_field("pixel_x", want.pixel_x, got.pixel_x);
      compare_field("pixel_y", want.pixel_y, got.pixel_y);
      compare_field("colour_index", want.colour_index, got.colour_index);
      compare_field("transparent", want.transparent, got.transparent);
      compare_field("plane_done", want.plane_done, got.plane_done);
      if (got.pixel_write) pixels++;
      if (got.plane_done) planes++;
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       cfg_write = 1'b0;
  logic [1:0]                 cfg_index = '0;
  logic [11:0]                cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [7:0]                 code_byte = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       pixel_write;
  logic signed [OUT_BITS-1:0] pixel_x;
  logic signed [OUT_BITS-1:0] pixel_y;
  logic [7:0]                 colour_index;
  logic                       transparent;
  logic                       plane_done;

  pixel_scoreboard sb;
  int send_gap_pct = 0;
  int stall_pct = 0;
  bit hold_request = 0;
  int bytes_sent = 0;
  int idle_cycles = 0;

  // Line end, a row run with a transparent pixel and an end byte inside it,
  // both skip forms, a long run, both two-byte forms (the one without skip
  // mode ends the line), the largest long-run step, an end byte as the second
  // byte of a two-byte command, and an end byte as a plain command.
  logic [7:0] directed_bytes [$] = '{
    8'h00, 8'h30, 8'h00, 8'hFF,
    8'h11, 8'h01, 8'h80,
    8'h2A, 8'h55, 8'hAA,
    8'h0F, 8'h83, 8'h01, 8'h02, 8'h03,
    8'hEF, 8'h20, 8'h10, 8'h20,
    8'hE8, 8'h1C, 8'hFE,
    8'hF0, 8'hE9, 8'hFF, 8'hFF
  };

  sprite_run_code_decoder dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .code_byte(code_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pixel_write(pixel_write),
    .pixel_x(pixel_x),
    .pixel_y(pixel_y),
    .colour_index(colour_index),
    .transparent(transparent),
    .plane_done(plane_done)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        sb.check_result({pixel_write, pixel_x, pixel_y, colour_index, transparent, plane_done});
      end
      if (in_valid && !in_stall) sb.note_byte(code_byte);
      if (cfg_write) sb.apply_reg(cfg_index, cfg_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $error("no item moved for %0d cycles, %0d results outstanding",
           WATCHDOG_LIMIT, sb.pending());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Receiver side: random stalls, plus one long hold-off per request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 0;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_stall = ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    code_byte = b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_colour();
    int r;
    r = $urandom_range(99);
    if (r < 12) return 8'h00;
    if (r < 14) return END_BYTE;
    return 8'($urandom_range(254, 1));
  endfunction

  task automatic send_run_data(input int count);
    repeat (count) send_byte(pick_colour());
  endtask

  // Mostly well-formed commands followed by exactly the data bytes their run
  // needs; the rest is raw noise, bare line ends and plane ends.
  task automatic send_sequence();
    int kind;
    logic [3:0] hi, lo;
    logic [7:0] second;
    kind = $urandom_range(99);
    if (kind < 12) begin
      send_byte(8'($urandom_range(255)));
    end else if (kind < 16) begin
      send_byte(END_BYTE);
    end else if (kind < 24) begin
      send_byte(8'h00);
    end else if (kind < 40) begin
      hi = 4'($urandom_range(7, 1));
      send_byte({hi, 4'h0});
      send_run_data(hi);
    end else if (kind < 54) begin
      hi = 4'($urandom_range(7));
      lo = 4'($urandom_range(7, 1));
      send_byte({hi, lo});
      send_run_data(hi + lo);
    end else if (kind < 68) begin
      hi = 4'($urandom_range(7));
      lo = 4'($urandom_range(15, 8));
      send_byte({hi, lo});
      send_run_data(hi);
    end else if (kind < 84) begin
      do {hi, lo} = 8'($urandom_range(254, 128));
      while ({hi, 4'h0} == CMD_E0 && lo > LO_MAX);
      send_byte({hi, lo});
      send_run_data(lo);
    end else begin
      lo = 4'($urandom_range(15, 8));
      second = 8'($urandom_range(254));
      send_byte({CMD_E0[7:4], lo});
      send_byte(second);
      send_run_data(second[7:4]);
    end
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic program_reg(input logic [1:0] idx, input logic [11:0] data);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
  endtask

  task automatic configure(input int p);
    case (p)
      0: begin
        program_reg(REG_X_BASE, 12'hFFF);
        program_reg(REG_Y_BASE, 12'hFFF);
        program_reg(REG_PLANE_INDEX, 12'd3);
      end
      1: begin
        program_reg(REG_X_BASE, 12'h000);
        program_reg(REG_Y_BASE, 12'h000);
        program_reg(REG_PLANE_INDEX, 12'h000);
      end
      // An unknown index must leave the decoder mid-plane, untouched.
      3: program_reg(REG_UNUSED, 12'($urandom));
      default: begin
        program_reg(REG_PLANE_INDEX, 12'($urandom));
        program_reg(REG_X_BASE, 12'($urandom));
        program_reg(REG_Y_BASE, 12'($urandom));
      end
    endcase
    cfg_write = 1'b0;
  endtask

  initial begin
    int target;
    sb = new();
    repeat (8) @(negedge clk);
    rst = 1'b0;
    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
    for (int p = 0; p < PHASES; p++) begin
      in_valid = 1'b0;
      wait_drained();
      configure(p);
      case (p % 4)
        0: begin
          send_gap_pct = 0;
          stall_pct = 0;
          hold_request = 1;
        end
        1: begin
          send_gap_pct = 51;
          stall_pct = 0;
        end
        2: begin
          send_gap_pct = 0;
          stall_pct = 51;
        end
        default: begin
          send_gap_pct = 15;
          stall_pct = 15;
        end
      endcase
      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) send_sequence();
    end
    in_valid = 1'b0;
    wait_drained();
    $display("Decoded %0d code bytes under %0d register settings and four handshake mixes,",
             bytes_sent, PHASES + 1);
    $display("with %0d pixels drawn and %0d plane ends.", sb.pixels, sb.planes);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sprite_run_code_decoder.f =====
design/srcd_pkg.sv
design/srcd_decode.sv
design/sprite_run_code_decoder.sv
tb/sprite_run_code_decoder_tb.sv
